@@ sv/mpms_pkg.sv @@
// ----------------------------------------------------------------------------
// mpms_pkg
// Shared constants, register indexes and sequencer states for the mesh point
// motion scale block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpms_pkg;

    // Field widths fixed by the interface
    localparam int DIST_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top-level parameters
    localparam int DIST_BITS_DEF       = 32;
    localparam int SCALE_FRAC_BITS_DEF = 16;
    localparam int COS_TABLE_STEPS_DEF = 256;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOVING_LAYER = 2'd0,
        CFG_STATIC_LAYER = 2'd1,
        CFG_MAX_DISTANCE = 2'd2,
        CFG_COSINE_MODE  = 2'd3
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP,
        ST_PREP,
        ST_SEL,
        ST_DEN,
        ST_DIV,
        ST_MAP,
        ST_MUL,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

@@ sv/mesh_point_motion_scale.sv @@
// Sequence: CMP, PREP, SEL, DEN, DIV, MAP, MUL, FIN, which loads the output
//   register once it is free; a deciding layer or max_distance test skips
//   SEL, DEN and DIV. The radix-2 divider makes one quotient bit per cycle.
// Flow: one point at a time; in_stall is high until the sequencer is idle.
// Reset: control state, overlap flag, configuration and out_valid return to
//   reset values at once; datapath registers are not reset; no clearing pass.
// ----------------------------------------------------------------------------
// mesh_point_motion_scale
// Per-point motion scale: layer tests, serial fractional divide and optional
// raised-cosine mapping through an interpolated constant table.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_point_motion_scale #(
    parameter int DIST_BITS       = mpms_pkg::DIST_BITS_DEF,
    parameter int SCALE_FRAC_BITS = mpms_pkg::SCALE_FRAC_BITS_DEF,
    parameter int COS_TABLE_STEPS = mpms_pkg::COS_TABLE_STEPS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [mpms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mpms_pkg::CFG_W-1:0]        cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [mpms_pkg::DIST_W-1:0]       dist_moving,
    input  wire logic [mpms_pkg::DIST_W-1:0]       dist_static,
    input  wire logic                              last_point,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [SCALE_FRAC_BITS:0]               scale,
    output logic                                   last_scale
);

    import mpms_pkg::*;

    localparam int DW  = (DIST_BITS < DIST_W) ? DIST_BITS : DIST_W;
    localparam int F   = SCALE_FRAC_BITS;
    localparam int IW  = $clog2(COS_TABLE_STEPS + 1);
    localparam int PW  = F + IW;
    localparam int CW  = $clog2(F);
    localparam logic [F:0] SCALE_ONE = {1'b1, {F{1'b0}}};

    // ------------------------------------------------------------------
    // Raised-cosine table, built at elaboration in Q60 fixed point
    // ------------------------------------------------------------------
    typedef logic [COS_TABLE_STEPS:0][F:0] cos_tab_t;

    localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;
    localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] X_STEP  = PI_Q60 / COS_TABLE_STEPS;
    localparam logic [63:0] X_REM   = PI_Q60 % COS_TABLE_STEPS;

    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // floor(a/b) by restoring shift and subtract, elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] cos_q60(input logic [63:0] j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] den;
        x    = X_STEP * j + div_u64(X_REM * j, 64'(COS_TABLE_STEPS));
        x2   = mul_q60(x, x);
        term = Q60_ONE;
        sum  = Q60_ONE;
        for (int n = 1; n < 40; n++) begin
            if (term != 64'd0) begin
                den  = 64'((2 * n - 1) * (2 * n));
                term = div_u64(mul_q60(term, x2), den);
                if ((n & 1) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic cos_tab_t build_cos_tab();
        cos_tab_t    tab;
        logic [63:0] v;
        logic [63:0] r;
        for (int k = 0; k <= COS_TABLE_STEPS; k++) begin
            if (2 * k <= COS_TABLE_STEPS)
                v = (Q60_ONE >> 1) - (cos_q60(64'(k)) >> 1);
            else
                v = (Q60_ONE >> 1) + (cos_q60(64'(COS_TABLE_STEPS - k)) >> 1);
            r = (v + (64'd1 << (59 - F))) >> (60 - F);
            tab[k] = r[F:0];
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t          state_reg, state_next;

    logic [DW-1:0]   moving_layer_reg, static_layer_reg, max_distance_reg;
    logic            cosine_mode_reg;
    logic            overlap_reg, overlap_next;

    logic [DW-1:0]   dm_reg, ds_reg;
    logic            last_reg;
    logic [DW-1:0]   mlay_reg, slay_reg;
    logic [DW-1:0]   mdif_reg, e1_reg, e2_reg;
    logic [DW-1:0]   den_reg, rem_reg;
    logic [F-1:0]    quo_reg;
    logic [CW-1:0]   cnt_reg;
    logic [F:0]      s_reg;
    logic [F:0]      lo_reg, dif_reg, prod_reg;
    logic [F-1:0]    frac_reg;

    logic            out_valid_reg;
    logic [F:0]      scale_reg;
    logic            last_scale_reg;

    logic            in_take;
    logic            out_load;
    logic            out_free;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_layer_reg <= '0;
            static_layer_reg <= '0;
            max_distance_reg <= '1;
            cosine_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MOVING_LAYER: moving_layer_reg <= cfg_data[DW-1:0];
                CFG_STATIC_LAYER: static_layer_reg <= cfg_data[DW-1:0];
                CFG_MAX_DISTANCE: max_distance_reg <= cfg_data[DW-1:0];
                CFG_COSINE_MODE:  cosine_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Layer overlap detection (sticky until the end of the pass)
    // ------------------------------------------------------------------
    logic [DW-1:0] ml_cur, sl_cur;
    logic          ov_hit;

    always_comb
    begin
        ml_cur       = overlap_reg ? '0 : moving_layer_reg;
        sl_cur       = overlap_reg ? '0 : static_layer_reg;
        ov_hit       = (dm_reg <= ml_cur) && (ds_reg <= sl_cur);
        overlap_next = overlap_reg;
        if (state_reg == ST_CMP)
            overlap_next = last_reg ? 1'b0 : (overlap_reg | ov_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            overlap_reg <= 1'b0;
        else
            overlap_reg <= overlap_next;
    end

    // ------------------------------------------------------------------
    // Distance differences; each test uses the borrow of its subtractor
    // ------------------------------------------------------------------
    logic [DW:0] sub_s, sub_m, sub_f;

    always_comb
    begin
        sub_s = {1'b0, ds_reg} - {1'b0, slay_reg};
        sub_m = {1'b0, dm_reg} - {1'b0, mlay_reg};
        sub_f = {1'b0, dm_reg} - {1'b0, max_distance_reg};
    end

    // ------------------------------------------------------------------
    // Divider step: one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [DW:0]   rem_sh;
    logic          q_bit;
    logic [DW-1:0] rem_new;

    always_comb
    begin
        rem_sh  = {rem_reg, 1'b0};
        q_bit   = (rem_sh >= {1'b0, den_reg});
        rem_new = q_bit ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
    end

    // ------------------------------------------------------------------
    // Cosine table lookup
    // ------------------------------------------------------------------
    logic [PW-1:0] pos;
    logic [IW-1:0] idx, lo_idx, hi_idx;
    logic [F:0]    tab_lo, tab_hi;

    always_comb
    begin
        pos    = PW'(s_reg) * PW'(COS_TABLE_STEPS);
        idx    = pos[PW-1:F];
        lo_idx = (idx >= IW'(COS_TABLE_STEPS)) ? IW'(COS_TABLE_STEPS) : idx;
        hi_idx = (idx >= IW'(COS_TABLE_STEPS)) ? IW'(COS_TABLE_STEPS) : IW'(idx + 1'b1);
        tab_lo = COS_TAB[lo_idx];
        tab_hi = COS_TAB[hi_idx];
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_CMP;
            ST_CMP:  state_next = ST_PREP;
            ST_PREP:
            begin
                if (sub_s[DW] || (sub_s[DW-1:0] == '0) ||
                    sub_m[DW] || (sub_m[DW-1:0] == '0) || !sub_f[DW])
                    state_next = ST_MAP;
                else
                    state_next = ST_SEL;
            end
            ST_SEL:  state_next = ST_DEN;
            ST_DEN:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_MAP;
            ST_MAP:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        in_stall = (state_reg != ST_IDLE);
        in_take  = in_valid && (state_reg == ST_IDLE);
        out_load = (state_reg == ST_FIN) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dm_reg   <= dist_moving[DW-1:0];
            ds_reg   <= dist_static[DW-1:0];
            last_reg <= last_point;
        end

        unique case (state_reg)
            ST_CMP:
            begin
                mlay_reg <= ov_hit ? '0 : ml_cur;
                slay_reg <= ov_hit ? '0 : sl_cur;
            end
            ST_PREP:
            begin
                mdif_reg <= sub_m[DW-1:0];
                e2_reg   <= sub_s[DW-1:0];
                e1_reg   <= DW'(max_distance_reg - dm_reg);
                // decided cases skip the divider
                if (sub_s[DW] || (sub_s[DW-1:0] == '0))
                    s_reg <= '0;
                else if (sub_m[DW] || (sub_m[DW-1:0] == '0))
                    s_reg <= SCALE_ONE;
                else
                    s_reg <= '0;
            end
            ST_SEL:
                rem_reg <= (e2_reg < e1_reg) ? e2_reg : e1_reg;
            ST_DEN:
            begin
                den_reg <= DW'(mdif_reg + rem_reg);
                cnt_reg <= CW'(F - 1);
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_new;
                quo_reg <= {quo_reg[F-2:0], q_bit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    s_reg <= {1'b0, quo_reg[F-2:0], q_bit};
            end
            ST_MAP:
            begin
                if (cosine_mode_reg)
                begin
                    lo_reg   <= tab_lo;
                    dif_reg  <= (tab_hi < tab_lo) ? '0 : (tab_hi - tab_lo);
                    frac_reg <= pos[F-1:0];
                end
                else
                begin
                    lo_reg   <= s_reg;
                    dif_reg  <= '0;
                    frac_reg <= '0;
                end
            end
            ST_MUL:
                prod_reg <= (F + 1)'(({{F{1'b0}}, dif_reg} *
                                      {{(F + 1){1'b0}}, frac_reg}) >> F);
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            scale_reg      <= (F + 1)'(lo_reg + prod_reg);
            last_scale_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scale      = scale_reg;
    assign last_scale = last_scale_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (scale <= SCALE_ONE))
        else $error("scale above full motion");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_CMP))
        else $error("accepted transaction did not start the sequencer");

    a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && last_reg) |=> !overlap_reg)
        else $error("overlap flag survived the end of the pass");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
